// ===== sv/rrbp_pkg.sv =====
// Shared constants and types for the replay ring buffer with purge.
`timescale 1ns / 1ps
package rrbp_pkg;

    localparam int DEPTH       = 1024;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ENTRY_BITS  = 64;
    localparam int DATA_W      = 64;
    localparam int RND_W       = 31;
    localparam int OCC_W       = 11;
    localparam int PURGE_W     = 10;
    localparam int PURGE_RESET = 204;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

endpackage

// ===== sv/rrbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rrbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rrbp_div.sv =====
// Restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module rrbp_div
    import rrbp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RND_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [CNT_W-1:0] o_remainder
);

    localparam int STEP_W = $clog2(RND_W);

    logic              r_active;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RND_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_dsr;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W:0]    n_shift;
    logic [CNT_W:0]    n_trial;
    logic [CNT_W-1:0]  n_rem;

    always_comb begin
        n_shift = {r_rem, r_dvd[RND_W-1]};
        n_trial = n_shift - {1'b0, r_dsr};
        if (n_trial[CNT_W]) begin
            n_rem = n_shift[CNT_W-1:0];
        end else begin
            n_rem = n_trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_step   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_step   <= '0;
                r_dvd    <= i_dividend;
                r_dsr    <= i_divisor;
                r_rem    <= '0;
            end else if (r_active) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[RND_W-2:0], 1'b0};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(RND_W - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

// ===== sv/replay_ring_buffer_with_purge_core.sv =====
// Top level of the replay ring buffer with purge.
`timescale 1ns / 1ps
// An add leaves busy low and the result strobes the next
// cycle. A sample of a non-empty store passes from accept to result
// strobe through the bit-serial remainder unit (one bit of
// random_value per cycle), a hand-off, a RAM read and the output
// register; busy is high until the output cycle, so the next beat can be
// taken at the edge that ends it. A sample of an empty store answers
// the next cycle with the error flag. The receiver cannot stall: each result
// is valid for exactly one cycle on o_result_valid.
module replay_ring_buffer_with_purge_core
    import rrbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_op,
    input  logic [DATA_W-1:0]     i_entry_data,
    input  logic [RND_W-1:0]      i_random_value,
    input  logic                  i_cfg_we,
    input  logic [PURGE_W-1:0]    i_cfg_wdata,
    output logic                  o_result_valid,
    output logic [DATA_W-1:0]     o_sample_data,
    output logic [OCC_W-1:0]      o_occupancy_count,
    output logic                  o_empty_error
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ
    } t_state;

    t_state               r_state;
    logic [IDX_W-1:0]     r_oldest;
    logic [IDX_W-1:0]     r_wr_idx;
    logic [CNT_W-1:0]     r_fill;
    logic [PURGE_W-1:0]   r_purge;
    logic                 r_valid;
    logic [DATA_W-1:0]    r_sample;
    logic                 r_err;

    logic                 n_accept;
    logic                 n_add;
    logic                 n_div_start;
    logic                 div_done;
    logic [CNT_W-1:0]     div_rem;
    logic [CNT_W-1:0]     n_purge;
    logic [CNT_W-1:0]     n_fill_inc;
    logic [IDX_W-1:0]     n_rd_addr;
    logic [ENTRY_BITS-1:0] ram_rdata;

    assign busy        = (r_state != ST_IDLE);
    assign n_accept    = start && !busy;
    assign n_add       = n_accept && (t_op'(i_op) == OP_ADD);
    assign n_div_start = n_accept && (t_op'(i_op) == OP_SAMPLE) && (r_fill != '0);
    assign n_fill_inc  = r_fill + 1'b1;
    assign n_rd_addr   = div_rem[IDX_W-1:0] + r_oldest;

    always_comb begin
        n_purge = CNT_W'(r_purge);
        if (r_purge == '0) begin
            n_purge = CNT_W'(1);
        end
        if (n_purge > CNT_W'(DEPTH)) begin
            n_purge = CNT_W'(DEPTH);
        end
    end

    rrbp_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (n_div_start),
        .i_dividend  (i_random_value),
        .i_divisor   (r_fill),
        .o_done      (div_done),
        .o_remainder (div_rem)
    );

    rrbp_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_add),
        .i_waddr (r_wr_idx),
        .i_wdata (ENTRY_BITS'(i_entry_data)),
        .i_re    (div_done),
        .i_raddr (n_rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_oldest <= '0;
            r_wr_idx <= '0;
            r_fill   <= '0;
            r_purge  <= PURGE_W'(PURGE_RESET);
            r_valid  <= 1'b0;
            r_err    <= 1'b0;
            r_sample <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_purge <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (n_add) begin
                        r_wr_idx <= r_wr_idx + 1'b1;
                        if (n_fill_inc == CNT_W'(DEPTH)) begin
                            r_fill   <= n_fill_inc - n_purge;
                            r_oldest <= r_oldest + n_purge[IDX_W-1:0];
                        end else begin
                            r_fill <= n_fill_inc;
                        end
                        r_valid  <= 1'b1;
                        r_err    <= 1'b0;
                        r_sample <= '0;
                    end else if (n_accept && r_fill == '0) begin
                        r_valid  <= 1'b1;
                        r_err    <= 1'b1;
                        r_sample <= '0;
                    end else if (n_div_start) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_valid  <= 1'b1;
                    r_err    <= 1'b0;
                    r_sample <= DATA_W'(ram_rdata);
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid    = r_valid;
    assign o_sample_data     = r_sample;
    assign o_occupancy_count = OCC_W'(r_fill);
    assign o_empty_error     = r_err;

endmodule
